/* design/tkenc_pkg.sv */
package tkenc_pkg;

   typedef enum logic [1:0] {
      CMD_TICK      = 2'd0,
      CMD_READ_MS   = 2'd1,
      CMD_READ_US   = 2'd2,
      CMD_TEST_FLAG = 2'd3
   } command_type;

   // event flag bit positions
   localparam logic [2:0] FLAG_COUNT_DOWN = 3'd0;
   localparam logic [2:0] FLAG_COUNT_UP   = 3'd1;
   localparam logic [2:0] FLAG_RELEASED   = 3'd2;
   localparam logic [2:0] FLAG_PRESSED    = 3'd3;
   localparam logic [2:0] FLAG_BUTTON     = 3'd4;

   // configuration register indexes
   localparam logic [1:0] REG_MILLI_STEP    = 2'd0;
   localparam logic [1:0] REG_FRACTION_STEP = 2'd1;
   localparam logic [1:0] REG_MICRO_SHIFT   = 2'd2;

   localparam logic [7:0] MILLI_STEP_RESET    = 8'd1;
   localparam logic [6:0] FRACTION_STEP_RESET = 7'd3;
   localparam logic [2:0] MICRO_SHIFT_RESET   = 3'd2;

   localparam logic [7:0] FRACTION_WRAP   = 8'd125;
   localparam logic [7:0] FRACTION_WRAP_2 = 8'd250;
   localparam logic [7:0] TIMER_TOP       = 8'hFF;

   typedef struct packed {
      logic [7:0] milli_step;
      logic [6:0] fraction_step;
      logic [2:0] micro_shift;
   } cfg_type;

   typedef struct packed {
      command_type command;
      logic [2:0]  pin_levels;
      logic [7:0]  timer_count;
      logic        overflow_pending;
      logic [2:0]  flag_index;
   } item_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] read_value;
   } result_type;

endpackage

/* design/tkenc_csr.sv */
module tkenc_csr
   import tkenc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output cfg_type     cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       write_en;
   logic [1:0] reg_index;

   assign csr_pready = 1'b1;
   assign write_en   = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_index  = csr_paddr[3:2];
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (reg_index)
            REG_MILLI_STEP:    cfg_in.milli_step    = csr_pwdata[7:0];
            REG_FRACTION_STEP: cfg_in.fraction_step = csr_pwdata[6:0];
            REG_MICRO_SHIFT:   cfg_in.micro_shift   = csr_pwdata[2:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_MILLI_STEP:    csr_prdata = {24'd0, cfg_ff.milli_step};
         REG_FRACTION_STEP: csr_prdata = {25'd0, cfg_ff.fraction_step};
         REG_MICRO_SHIFT:   csr_prdata = {29'd0, cfg_ff.micro_shift};
         default:           csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.milli_step    <= MILLI_STEP_RESET;
         cfg_ff.fraction_step <= FRACTION_STEP_RESET;
         cfg_ff.micro_shift   <= MICRO_SHIFT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* design/tkenc_core.sv */
module tkenc_core
   import tkenc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       fire,
   input  item_type   item,
   output result_type result
);

   logic [31:0] milli_ff,    milli_in;
   logic [6:0]  frac_ff,     frac_in;
   logic [31:0] overflow_ff, overflow_in;
   logic [2:0]  prev_ff,     prev_in;
   logic [4:0]  flags_ff,    flags_in;

   logic [7:0]  frac_sum;
   logic [7:0]  frac_left;
   logic [1:0]  frac_carry;
   logic [2:0]  cur;
   logic [1:0]  prev_ab;
   logic [1:0]  cur_ab;
   logic [31:0] overflow_seen;
   logic [31:0] timer_total;
   logic        flag_bit;

   // fraction wraps at 125; the sum stays below three wraps
   always_comb begin
      frac_sum = {1'b0, frac_ff} + {1'b0, cfg.fraction_step};
      if (frac_sum >= FRACTION_WRAP_2) begin
         frac_left  = frac_sum - FRACTION_WRAP_2;
         frac_carry = 2'd2;
      end else if (frac_sum >= FRACTION_WRAP) begin
         frac_left  = frac_sum - FRACTION_WRAP;
         frac_carry = 2'd1;
      end else begin
         frac_left  = frac_sum;
         frac_carry = 2'd0;
      end
   end

   assign cur     = ~item.pin_levels;
   assign prev_ab = prev_ff[2:1];
   assign cur_ab  = cur[2:1];

   // a pending overflow at the timer top is already counted
   assign overflow_seen = overflow_ff +
      {31'd0, item.overflow_pending & (item.timer_count != TIMER_TOP)};
   assign timer_total   = {overflow_seen[23:0], item.timer_count} << cfg.micro_shift;

   always_comb begin
      case (item.flag_index)
         FLAG_COUNT_DOWN: flag_bit = flags_ff[FLAG_COUNT_DOWN];
         FLAG_COUNT_UP:   flag_bit = flags_ff[FLAG_COUNT_UP];
         FLAG_RELEASED:   flag_bit = flags_ff[FLAG_RELEASED];
         FLAG_PRESSED:    flag_bit = flags_ff[FLAG_PRESSED];
         FLAG_BUTTON:     flag_bit = flags_ff[FLAG_BUTTON];
         default:         flag_bit = 1'b0;
      endcase
   end

   always_comb begin
      milli_in          = milli_ff;
      frac_in           = frac_ff;
      overflow_in       = overflow_ff;
      prev_in           = prev_ff;
      flags_in          = flags_ff;
      result.valid      = 1'b0;
      result.read_value = 32'd0;
      case (item.command)
         CMD_TICK: begin
            milli_in    = milli_ff + {24'd0, cfg.milli_step} + {30'd0, frac_carry};
            frac_in     = frac_left[6:0];
            overflow_in = overflow_ff + 32'd1;
            prev_in     = cur;
            flags_in[FLAG_BUTTON] = cur[0];
            if (cur[0] & ~prev_ff[0]) begin
               flags_in[FLAG_PRESSED] = 1'b1;
            end
            if (~cur[0] & prev_ff[0]) begin
               flags_in[FLAG_RELEASED] = 1'b1;
            end
            // one count per detent: AB 00 to 01 up, 01 to 00 down
            if (prev_ab == 2'b00 && cur_ab == 2'b01) begin
               flags_in[FLAG_COUNT_UP] = 1'b1;
            end else if (prev_ab == 2'b01 && cur_ab == 2'b00) begin
               flags_in[FLAG_COUNT_DOWN] = 1'b1;
            end
         end
         CMD_READ_MS: begin
            result.valid      = 1'b1;
            result.read_value = milli_ff;
         end
         CMD_READ_US: begin
            result.valid      = 1'b1;
            result.read_value = timer_total;
         end
         CMD_TEST_FLAG: begin
            result.valid      = 1'b1;
            result.read_value = {31'd0, flag_bit};
            if (flag_bit && item.flag_index != FLAG_BUTTON) begin
               case (item.flag_index)
                  FLAG_COUNT_DOWN: flags_in[FLAG_COUNT_DOWN] = 1'b0;
                  FLAG_COUNT_UP:   flags_in[FLAG_COUNT_UP]   = 1'b0;
                  FLAG_RELEASED:   flags_in[FLAG_RELEASED]   = 1'b0;
                  FLAG_PRESSED:    flags_in[FLAG_PRESSED]    = 1'b0;
                  default: ;
               endcase
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         milli_ff    <= 32'd0;
         frac_ff     <= 7'd0;
         overflow_ff <= 32'd0;
         prev_ff     <= 3'd0;
         flags_ff    <= 5'd0;
      end else if (fire) begin
         milli_ff    <= milli_in;
         frac_ff     <= frac_in;
         overflow_ff <= overflow_in;
         prev_ff     <= prev_in;
         flags_ff    <= flags_in;
      end
   end

endmodule

/* design/tick_timekeeper_with_encoder_flags_unit.sv */
// Millisecond timekeeper with button and quadrature encoder event flags.
// Request channel (req_*): one transfer per command. tuser carries the
// command (tick, read milliseconds, read microseconds, test flag); tdata
// carries the sampled pins, timer count, pending overflow and flag index.
// A tick advances the millisecond, fraction and overflow counters and
// updates the event flags from the pins; it produces no response.
// Every other command produces one response transfer on rsp_* holding
// the 32-bit read value.
// A request enters an input register and executes from there, loading
// the output register that drives rsp_tvalid. Throughput: one request
// per cycle unless a read waits on a full output register, set by the
// single execute stage; the next request is taken while a finished
// response still waits.
// When the receiver stalls, the response holds in the output register and
// further reads back up into the input register, then req_tready drops.
// Ticks keep executing during a stall since they need no output slot.
// Reset clears all counters and flags and sets the step registers to
// 1 ms, 3 fraction units and a shift of 2. Configure only while idle.
module tick_timekeeper_with_encoder_flags_unit
   import tkenc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // pin_levels[2:0], timer_count[10:3],
                                   // overflow_pending[11], flag_index[14:12]
   input  logic [1:0]  req_tuser,  // command[1:0]
   // response
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // read_value[31:0]
   // configuration
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   cfg_type     cfg;
   item_type    item_ff,      item_in;
   logic        item_valid_ff, item_valid_in;
   logic        rsp_valid_ff,  rsp_valid_in;
   logic [31:0] rsp_data_ff,   rsp_data_in;
   result_type  result;
   logic        out_free;
   logic        fire;
   logic        req_take;

   tkenc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   tkenc_core u_core (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .fire   (fire),
      .item   (item_ff),
      .result (result)
   );

   assign out_free   = ~rsp_valid_ff | rsp_tready;
   assign fire       = item_valid_ff & ((item_ff.command == CMD_TICK) | out_free);
   assign req_tready = ~item_valid_ff | fire;
   assign req_take   = req_tvalid & req_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      item_in                  = item_ff;
      item_in.command          = command_type'(req_tuser);
      item_in.pin_levels       = req_tdata[2:0];
      item_in.timer_count      = req_tdata[10:3];
      item_in.overflow_pending = req_tdata[11];
      item_in.flag_index       = req_tdata[14:12];
   end

   always_comb begin
      item_valid_in = item_valid_ff;
      if (req_take) begin
         item_valid_in = 1'b1;
      end else if (fire) begin
         item_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      // load a fresh response; fire only passes a read when the slot is free
      if (fire && result.valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result.read_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff <= item_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

endmodule
